FILE: rtl/u8e_pkg.sv
// ---------------------------------------------------------------------------
// u8e_pkg
// shared types and constants of the wide character to utf-8 encoder
// ---------------------------------------------------------------------------
package u8e_pkg;

   // surrogate ranges and code point limits
   localparam logic [31:0] HIGH_SURR_FIRST = 32'h0000_D800;
   localparam logic [31:0] HIGH_SURR_LAST  = 32'h0000_DBFF;
   localparam logic [31:0] LOW_SURR_FIRST  = 32'h0000_DC00;
   localparam logic [31:0] LOW_SURR_LAST   = 32'h0000_DFFF;
   localparam logic [31:0] MAX_CODE_POINT  = 32'h0010_FFFF;
   localparam logic [20:0] REPLACEMENT_CP  = 21'h00_FFFD;
   localparam logic [20:0] SUPP_BASE       = 21'h01_0000;

   // length class limits
   localparam logic [20:0] MAX_ONE_BYTE    = 21'h00_007F;
   localparam logic [20:0] MAX_TWO_BYTE    = 21'h00_07FF;
   localparam logic [20:0] MAX_THREE_BYTE  = 21'h00_FFFF;

   // utf-8 bytes of the replacement character
   localparam logic [7:0] REPL_BYTE0 = 8'hEF;
   localparam logic [7:0] REPL_BYTE1 = 8'hBF;
   localparam logic [7:0] REPL_BYTE2 = 8'hBD;
   localparam logic [1:0] REPL_LAST_IDX = 2'd2;

   // byte index codes within one code point
   localparam logic [1:0] IDX_FIRST = 2'd0;

   // lead and continuation prefixes
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;
   localparam logic [1:0] CONT_TAG  = 2'b10;

   // one queued job: optional replacement prefix, then an optional code point
   typedef struct packed {
      logic        has_prefix;
      logic        has_main;
      logic [20:0] code_point;
   } job_type;

endpackage

FILE: rtl/u8e_front.sv
// ---------------------------------------------------------------------------
// u8e_front
// accepts wide units, pairs surrogates and issues encoding jobs
// ---------------------------------------------------------------------------
module u8e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic              push,
   output logic              full,
   input  logic [31:0]       req_code_unit,
   input  logic              req_end_of_string,
   input  logic              job_full,
   output logic              job_push,
   output u8e_pkg::job_type  job_data
);

   logic       pair_ff, pair_in;
   logic       pending_ff, pending_in;
   logic [9:0] held_ff, held_in;

   logic       accept;
   logic       is_high;
   logic       is_low;
   logic       out_of_range;
   logic       pend;
   logic [20:0] plain_cp;
   logic [20:0] joined_cp;
   u8e_pkg::job_type job;
   logic       hold_new;

   // classify the incoming unit
   assign is_high = (req_code_unit >= u8e_pkg::HIGH_SURR_FIRST) &&
                    (req_code_unit <= u8e_pkg::HIGH_SURR_LAST);
   assign is_low  = (req_code_unit >= u8e_pkg::LOW_SURR_FIRST) &&
                    (req_code_unit <= u8e_pkg::LOW_SURR_LAST);
   assign out_of_range = req_code_unit > u8e_pkg::MAX_CODE_POINT;
   assign pend = pair_ff && pending_ff;

   assign plain_cp  = (is_high || is_low || out_of_range) ? u8e_pkg::REPLACEMENT_CP
                                                          : req_code_unit[20:0];
   assign joined_cp = u8e_pkg::SUPP_BASE + {1'b0, held_ff, req_code_unit[9:0]};

   assign accept = push && !job_full;
   assign full   = job_full;

   // build the job for this unit
   always_comb begin
      job.has_prefix = 1'b0;
      job.has_main   = 1'b1;
      job.code_point = plain_cp;
      hold_new       = 1'b0;
      if (!pair_ff) begin
         job.code_point = plain_cp;
      end else if (pend && is_low) begin
         job.code_point = joined_cp;
      end else begin
         job.has_prefix = pend;
         if (is_high && !req_end_of_string) begin
            job.has_main = 1'b0;
            hold_new     = 1'b1;
         end
      end
   end

   assign job_push = accept && (job.has_prefix || job.has_main);
   assign job_data = job;

   // held surrogate and mode register
   always_comb begin
      pair_in    = pair_ff;
      pending_in = pending_ff;
      held_in    = held_ff;
      if (csr_wr_en) begin
         pair_in    = csr_wr_data;
         pending_in = 1'b0;
         held_in    = '0;
      end else if (accept && pair_ff) begin
         pending_in = hold_new;
         held_in    = hold_new ? req_code_unit[9:0] : 10'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff    <= 1'b1;
         pending_ff <= 1'b0;
         held_ff    <= '0;
      end else begin
         pair_ff    <= pair_in;
         pending_ff <= pending_in;
         held_ff    <= held_in;
      end
   end

endmodule

FILE: rtl/u8e_queue.sv
// ---------------------------------------------------------------------------
// u8e_queue
// short job queue between the front and the byte sequencer
// ---------------------------------------------------------------------------
module u8e_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  u8e_pkg::job_type  wr_data,
   output logic              q_full,
   input  logic              rd_en,
   output u8e_pkg::job_type  rd_data,
   output logic              q_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   u8e_pkg::job_type   mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign q_full  = count_ff == CNT_W'(DEPTH);
   assign q_empty = count_ff == '0;
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // job storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/u8e_back.sv
// ---------------------------------------------------------------------------
// u8e_back
// walks each job into the result register one utf-8 byte per cycle while the result register is free or popped
// ---------------------------------------------------------------------------
module u8e_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  u8e_pkg::job_type  job,
   output logic              job_pop,
   output logic              empty,
   input  logic              pop,
   output logic [7:0]        rsp_utf8_byte,
   output logic              rsp_last_of_run
);

   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       pre_done_ff, pre_done_in;

   logic       in_prefix;
   logic [1:0] len_m1;
   logic [1:0] shift_sel;
   logic [5:0] six_bits;
   logic [7:0] prefix_byte;
   logic [7:0] main_byte;
   logic       job_end;
   logic       step_go;

   // length of the code point in bytes, minus one
   always_comb begin
      priority if (job.code_point <= u8e_pkg::MAX_ONE_BYTE) begin
         len_m1 = 2'd0;
      end else if (job.code_point <= u8e_pkg::MAX_TWO_BYTE) begin
         len_m1 = 2'd1;
      end else if (job.code_point <= u8e_pkg::MAX_THREE_BYTE) begin
         len_m1 = 2'd2;
      end else begin
         len_m1 = 2'd3;
      end
   end

   assign in_prefix = job.has_prefix && !pre_done_ff;

   // replacement character bytes
   always_comb begin
      unique case (idx_ff)
         2'd0:    prefix_byte = u8e_pkg::REPL_BYTE0;
         2'd1:    prefix_byte = u8e_pkg::REPL_BYTE1;
         default: prefix_byte = u8e_pkg::REPL_BYTE2;
      endcase
   end

   // continuation payload picked by remaining byte count
   assign shift_sel = len_m1 - idx_ff;
   always_comb begin
      unique case (shift_sel)
         2'd0:    six_bits = job.code_point[5:0];
         2'd1:    six_bits = job.code_point[11:6];
         default: six_bits = job.code_point[17:12];
      endcase
   end

   // lead or continuation byte of the code point
   always_comb begin
      if (idx_ff == u8e_pkg::IDX_FIRST) begin
         unique case (len_m1)
            2'd0:    main_byte = {1'b0, job.code_point[6:0]};
            2'd1:    main_byte = {u8e_pkg::LEAD2_TAG, job.code_point[10:6]};
            2'd2:    main_byte = {u8e_pkg::LEAD3_TAG, job.code_point[15:12]};
            default: main_byte = {u8e_pkg::LEAD4_TAG, job.code_point[20:18]};
         endcase
      end else begin
         main_byte = {u8e_pkg::CONT_TAG, six_bits};
      end
   end

   assign job_end = in_prefix ? ((idx_ff == u8e_pkg::REPL_LAST_IDX) && !job.has_main)
                              : (idx_ff == len_m1);
   assign step_go = job_valid && (!out_valid_ff || pop);
   assign job_pop = step_go && job_end;

   // sequencer and result register
   always_comb begin
      out_valid_in = out_valid_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      pre_done_in  = pre_done_ff;
      if (step_go) begin
         out_valid_in = 1'b1;
         byte_in      = in_prefix ? prefix_byte : main_byte;
         last_in      = job_end;
         if (job_end) begin
            idx_in      = u8e_pkg::IDX_FIRST;
            pre_done_in = 1'b0;
         end else if (in_prefix && (idx_ff == u8e_pkg::REPL_LAST_IDX)) begin
            idx_in      = u8e_pkg::IDX_FIRST;
            pre_done_in = 1'b1;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= u8e_pkg::IDX_FIRST;
         pre_done_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         idx_ff       <= idx_in;
         pre_done_ff  <= pre_done_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign empty           = !out_valid_ff;
   assign rsp_utf8_byte   = byte_ff;
   assign rsp_last_of_run = last_ff;

endmodule

FILE: rtl/wide_char_to_utf8_encoder_core.sv
// ---------------------------------------------------------------------------
// wide_char_to_utf8_encoder_core
// wide unit to utf-8 byte encoder with surrogate pairing
// ---------------------------------------------------------------------------
//  channel  | ports                                        | transfer
//  ---------+----------------------------------------------+---------------------
//  input    | push, full, req_code_unit, req_end_of_string | push & !full
//  result   | empty, pop, rsp_utf8_byte, rsp_last_of_run   | !empty & pop
//  control  | csr_wr_en, csr_wr_data                       | csr_wr_en
//
// the front takes one unit per cycle while the job queue has room
// the byte sequencer emits one byte per cycle while the result side pops, so a unit
// yields 0 to 7 bytes (1 to 4 for an ordinary code point)
// synchronous reset empties the queue and result register, mode reverts to pairing
// a stalled result side fills the queue, then full rises and holds the input side
// ---------------------------------------------------------------------------
module wide_char_to_utf8_encoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_code_unit,
   input  logic        req_end_of_string,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_utf8_byte,
   output logic        rsp_last_of_run
);

   logic             q_full;
   logic             q_empty;
   logic             q_push;
   logic             q_pop;
   u8e_pkg::job_type q_wr_data;
   u8e_pkg::job_type q_rd_data;

   // unit classification and surrogate pairing
   u8e_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .push              (push),
      .full              (full),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .job_full          (q_full),
      .job_push          (q_push),
      .job_data          (q_wr_data)
   );

   // job queue
   u8e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr_data),
      .q_full  (q_full),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .q_empty (q_empty)
   );

   // byte sequencer
   u8e_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (!q_empty),
      .job             (q_rd_data),
      .job_pop         (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_utf8_byte   (rsp_utf8_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

FILE: rtl/u8e_checker.sv
// ---------------------------------------------------------------------------
// u8e_checker
// port level checks of the encoder, attached by bind
// ---------------------------------------------------------------------------
module u8e_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_utf8_byte,
   input logic       rsp_last_of_run
);

   // a waiting result transaction holds until taken
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_utf8_byte) && $stable(rsp_last_of_run)))
      else $error("result changed while stalled");

   // reset leaves both sides idle
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("not idle after reset");

   // a run never ends on a multi-byte lead byte
   a_last_not_lead: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_last_of_run) |-> (rsp_utf8_byte[7:6] != 2'b11))
      else $error("run ends on a lead byte");

   // overlong and out of range lead bytes never appear
   a_legal_byte: assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_utf8_byte != 8'hC0) && (rsp_utf8_byte != 8'hC1) &&
                  (rsp_utf8_byte < 8'hF5)))
      else $error("illegal utf-8 byte");

   // a queue that was already full and is still full always has a result on show
   a_full_has_result: assert property (@(posedge clock) disable iff (reset)
      (full && $past(full) && !$past(reset)) |-> !empty)
      else $error("queue full with no result on show");

endmodule

bind wide_char_to_utf8_encoder_core u8e_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_utf8_byte   (rsp_utf8_byte),
   .rsp_last_of_run (rsp_last_of_run)
);

FILE: bench/tb_wide_char_to_utf8_encoder_core.sv
// ---------------------------------------------------------------------------
// tb_wide_char_to_utf8_encoder_core
// self-checking bench for the wide unit to utf-8 byte encoder
//
// a driver pushes wide units from a queue and a monitor pops utf-8 bytes,
// each byte being checked against the bytes predicted for the units taken.
// directed units cover the length classes, surrogate pairs, unpaired and
// late surrogates and out-of-range values; random strings follow in both
// modes, with either side idling at random in all but the last run.
// ---------------------------------------------------------------------------
module tb_wide_char_to_utf8_encoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_32BIT  = 1'b0;
   localparam logic MODE_PAIRED = 1'b1;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      logic [31:0] unit;
      logic        eos;
   } wide_unit_type;

   typedef struct {
      logic [7:0] utf8;
      logic       last;
   } utf8_out_type;

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        csr_wr_en         = 1'b0;
   logic        csr_wr_data       = 1'b0;
   logic        push              = 1'b0;
   logic        full;
   logic [31:0] req_code_unit     = '0;
   logic        req_end_of_string = 1'b0;
   logic        empty;
   logic        pop               = 1'b0;
   logic [7:0]  rsp_utf8_byte;
   logic        rsp_last_of_run;

   // units waiting to be pushed and bytes waiting to be popped
   wide_unit_type units_to_send[$];
   utf8_out_type  bytes_due[$];
   wide_unit_type staged;

   // encoder state as the bench sees it
   logic       pair_mode  = MODE_PAIRED;
   logic       high_held  = 1'b0;
   logic [9:0] held_bits  = '0;
   int         step_bytes;

   int sender_idle_pct = 0;
   int reader_idle_pct = 0;
   bit unit_taken      = 1'b0;

   int failures      = 0;
   int units_taken   = 0;
   int bytes_checked = 0;
   int csr_writes    = 0;

   wide_char_to_utf8_encoder_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .push              (push),
      .full              (full),
      .req_code_unit     (req_code_unit),
      .req_end_of_string (req_end_of_string),
      .empty             (empty),
      .pop               (pop),
      .rsp_utf8_byte     (rsp_utf8_byte),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one predicted byte at the tail of the expected list
   function automatic void append_byte(input logic [7:0] b);
      bytes_due.insert(bytes_due.size(), '{b, 1'b0});
      step_bytes += 1;
   endfunction

   // queue one code point as utf-8 bytes, out-of-range values as replacement
   function automatic void put_code_point(input logic [31:0] cp);
      logic [20:0] c;
      if (cp > u8e_pkg::MAX_CODE_POINT) c = u8e_pkg::REPLACEMENT_CP;
      else c = cp[20:0];
      if (c <= u8e_pkg::MAX_ONE_BYTE) begin
         append_byte(c[7:0]);
      end else if (c <= u8e_pkg::MAX_TWO_BYTE) begin
         append_byte({u8e_pkg::LEAD2_TAG, c[10:6]});
         append_byte({u8e_pkg::CONT_TAG, c[5:0]});
      end else if (c <= u8e_pkg::MAX_THREE_BYTE) begin
         append_byte({u8e_pkg::LEAD3_TAG, c[15:12]});
         append_byte({u8e_pkg::CONT_TAG, c[11:6]});
         append_byte({u8e_pkg::CONT_TAG, c[5:0]});
      end else begin
         append_byte({u8e_pkg::LEAD4_TAG, c[20:18]});
         append_byte({u8e_pkg::CONT_TAG, c[17:12]});
         append_byte({u8e_pkg::CONT_TAG, c[11:6]});
         append_byte({u8e_pkg::CONT_TAG, c[5:0]});
      end
   endfunction

   // bytes that one accepted unit produces, last one flagged
   function automatic void encode_unit(input logic [31:0] unit, input logic eos);
      logic        is_high;
      logic        is_low;
      logic [31:0] joined;
      step_bytes = 0;
      is_high = (unit >= u8e_pkg::HIGH_SURR_FIRST) && (unit <= u8e_pkg::HIGH_SURR_LAST);
      is_low  = (unit >= u8e_pkg::LOW_SURR_FIRST) && (unit <= u8e_pkg::LOW_SURR_LAST);
      if (pair_mode == MODE_32BIT) begin
         put_code_point((is_high || is_low) ? 32'(u8e_pkg::REPLACEMENT_CP) : unit);
      end else if (high_held && is_low) begin
         // held high joined with this low surrogate
         joined = 32'(u8e_pkg::SUPP_BASE) + (32'(held_bits) << 10) +
                  (unit - u8e_pkg::LOW_SURR_FIRST);
         high_held = 1'b0;
         held_bits = '0;
         put_code_point(joined);
      end else begin
         // a held high with no low after it is replaced first
         if (high_held) begin
            high_held = 1'b0;
            held_bits = '0;
            put_code_point(32'(u8e_pkg::REPLACEMENT_CP));
         end
         if (is_high) begin
            if (eos) begin
               put_code_point(32'(u8e_pkg::REPLACEMENT_CP));
            end else begin
               high_held = 1'b1;
               held_bits = 10'(unit - u8e_pkg::HIGH_SURR_FIRST);
            end
         end else if (is_low) begin
            put_code_point(32'(u8e_pkg::REPLACEMENT_CP));
         end else begin
            put_code_point(unit);
         end
      end
      if (step_bytes > 0) begin
         bytes_due[bytes_due.size() - 1].last = 1'b1;
      end
   endfunction

   // driver: next unit and pop decision at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         push <= 1'b0;
         pop  <= 1'b0;
      end else begin
         if (!push || unit_taken) begin
            unit_taken = 1'b0;
            if (units_to_send.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               staged = units_to_send.pop_front();
               push              <= 1'b1;
               req_code_unit     <= staged.unit;
               req_end_of_string <= staged.eos;
            end else begin
               push <= 1'b0;
            end
         end
         pop <= ($urandom_range(99) >= reader_idle_pct);
      end
   end

   // monitor: check popped bytes, predict for pushed units
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            bytes_checked++;
            if (bytes_due.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected byte %02h last %0b", rsp_utf8_byte, rsp_last_of_run);
            end else if (bytes_due[0].utf8 !== rsp_utf8_byte ||
                         bytes_due[0].last !== rsp_last_of_run) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                           bytes_due[0].utf8, bytes_due[0].last,
                           rsp_utf8_byte, rsp_last_of_run);
               void'(bytes_due.pop_front());
            end else begin
               void'(bytes_due.pop_front());
            end
         end
         if (push && !full) begin
            encode_unit(req_code_unit, req_end_of_string);
            units_taken++;
            unit_taken = 1'b1;
         end
      end
   end

   // run time guard
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   task automatic send(input logic [31:0] unit, input logic eos);
      units_to_send.insert(units_to_send.size(), '{unit, eos});
   endtask

   // random strings, mostly well formed, some broken
   task automatic queue_random_units(input int count);
      int          added;
      int          kind;
      logic [31:0] u;
      added = 0;
      while (added < count) begin
         kind = $urandom_range(99);
         if (kind < 20) begin
            send($urandom_range(32'h7F), ($urandom_range(9) == 0));
         end else if (kind < 32) begin
            send($urandom_range(32'h7FF, 32'h80), ($urandom_range(9) == 0));
         end else if (kind < 44) begin
            u = $urandom_range(1) ? $urandom_range(32'hD7FF, 32'h800)
                                  : $urandom_range(32'hFFFF, 32'hE000);
            send(u, ($urandom_range(9) == 0));
         end else if (kind < 54) begin
            send($urandom_range(32'h10FFFF, 32'h10000), ($urandom_range(9) == 0));
         end else if (kind < 74) begin
            send(u8e_pkg::HIGH_SURR_FIRST + $urandom_range(1023), 1'b0);
            send(u8e_pkg::LOW_SURR_FIRST + $urandom_range(1023), ($urandom_range(9) == 0));
            added++;
         end else if (kind < 80) begin
            send(u8e_pkg::HIGH_SURR_FIRST + $urandom_range(1023), ($urandom_range(1) == 1));
         end else if (kind < 86) begin
            send(u8e_pkg::LOW_SURR_FIRST + $urandom_range(1023), ($urandom_range(1) == 1));
         end else if (kind < 90) begin
            send(u8e_pkg::HIGH_SURR_FIRST + $urandom_range(1023), 1'b1);
         end else if (kind < 96) begin
            send($urandom_range(32'hFFFF_FFFF, 32'h11_0000), ($urandom_range(1) == 1));
         end else begin
            send($urandom, ($urandom_range(1) == 1));
         end
         added++;
      end
   endtask

   // sender holds off until every predicted byte has been popped
   task automatic wait_until_drained();
      while (units_to_send.size() != 0 || push || bytes_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mode write, only while the encoder is idle
   task automatic write_pairing(input logic mode);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      pair_mode = mode;
      high_held = 1'b0;
      held_bits = '0;
      csr_writes++;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed units in pairing mode, the reset setting
      sender_idle_pct = 17;
      reader_idle_pct = 51;
      send(32'h0000_0000, 1'b0);
      send(32'h0000_007F, 1'b0);
      send(32'h0000_0080, 1'b0);
      send(32'h0000_07FF, 1'b0);
      send(32'h0000_0800, 1'b0);
      send(32'h0000_FFFF, 1'b0);
      send(32'h0001_0000, 1'b0);
      send(32'h0010_FFFF, 1'b0);
      send(32'h0011_0000, 1'b0);
      send(32'hFFFF_FFFF, 1'b1);
      // pairs at both ends of the surrogate ranges
      send(32'h0000_D800, 1'b0);
      send(32'h0000_DC00, 1'b0);
      send(32'h0000_DBFF, 1'b0);
      send(32'h0000_DFFF, 1'b0);
      // held high followed by a plain unit, then by another high
      send(32'h0000_D801, 1'b0);
      send(32'h0000_0041, 1'b0);
      send(32'h0000_D802, 1'b0);
      send(32'h0000_DBFE, 1'b0);
      send(32'h0000_DC01, 1'b0);
      // high surrogate on the last unit, with and without one held
      send(32'h0000_DABC, 1'b1);
      send(32'h0000_D900, 1'b0);
      send(32'h0000_DA00, 1'b1);
      // lone low surrogates and the replacement itself
      send(32'h0000_DC00, 1'b0);
      send(32'h0000_DFFF, 1'b1);
      send(32'h0000_FFFD, 1'b0);
      wait_until_drained();

      // 32-bit mode, surrogates never pair
      write_pairing(MODE_32BIT);
      queue_random_units(90);
      wait_until_drained();

      // pairing mode, ending with a held high that the next write drops
      write_pairing(MODE_PAIRED);
      queue_random_units(100);
      send(32'h0000_D812, 1'b0);
      wait_until_drained();

      sender_idle_pct = 51;
      reader_idle_pct = 17;
      write_pairing(MODE_PAIRED);
      send(32'h0000_DC05, 1'b0);
      queue_random_units(100);
      wait_until_drained();

      write_pairing(MODE_32BIT);
      queue_random_units(40);
      wait_until_drained();

      // no idling on either side
      sender_idle_pct = 0;
      reader_idle_pct = 0;
      write_pairing(MODE_PAIRED);
      queue_random_units(25);
      wait_until_drained();

      if (bytes_due.size() != 0) failures += bytes_due.size();
      $display("%0d wide units pushed over %0d mode writes, %0d utf-8 bytes checked",
               units_taken, csr_writes, bytes_checked);
      $display("both modes, surrogate pairs, unpaired surrogates, out-of-range values");
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", failures);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
